// ----- hw/rtl/pdu_pkg.sv -----
`timescale 1ns / 1ps

package pdu_pkg;

   // Field widths of the cell and pixel channels.
   localparam int UP_W    = 4;
   localparam int COEF_W  = 16;
   localparam int BATCH_W = 4;
   localparam int CROW_W  = 8;
   localparam int CCOL_W  = 9;
   localparam int PROW_W  = 11;
   localparam int PCOL_W  = 12;
   localparam int DEPTH_W = 24;

   // Datapath widths.
   localparam int TOFS_W  = 5;   // doubled sub-pixel offset, signed
   localparam int SQX_W   = 62;  // radicand of the square root
   localparam int ROOT_W  = 31;  // square root result
   localparam int DEN_W   = 35;  // signed denominator
   localparam int DMAG_W  = 35;  // denominator magnitude
   localparam int NMAG_W  = 48;  // numerator magnitude
   localparam int NUM_W   = 49;  // rounded dividend
   localparam int DIV_W   = 36;  // doubled divisor
   localparam int QUO_W   = 25;  // quotient bits resolved by the divider
   localparam int CMP_W   = DIV_W + QUO_W;
   localparam int SQ_STAGES  = ROOT_W;
   localparam int DIV_STAGES = QUO_W;

   localparam logic [DEPTH_W-1:0] DEPTH_POS_MAX = 24'h7F_FFFF;
   localparam logic [QUO_W-1:0]   DEPTH_NEG_MAG = 25'h080_0000;
   localparam logic [QUO_W-1:0]   DEPTH_POS_MAG = 25'h07F_FFFF;

   // Per-pixel position data that travels beside the arithmetic.
   typedef struct packed {
      logic [BATCH_W-1:0] batch;
      logic [PROW_W-1:0]  row;
      logic [PCOL_W-1:0]  col;
      logic               last;
   } pdu_side_type;

   // One sub-pixel job handed from the sequencer to the datapath.
   typedef struct packed {
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic signed [COEF_W-1:0] c;
      logic signed [COEF_W-1:0] d;
      logic [COEF_W-1:0]        f;
      logic signed [TOFS_W-1:0] tu;
      logic signed [TOFS_W-1:0] tv;
      pdu_side_type             side;
   } pdu_pix_type;

   // Flags carried through the root and divider sections.
   typedef struct packed {
      pdu_side_type side;
      logic         zero;
      logic         neg;
   } pdu_carry_type;

endpackage

// ----- hw/rtl/pdu_if.sv -----
`timescale 1ns / 1ps

// Cell channel.
interface pdu_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] plane_a;
   logic [15:0] plane_b;
   logic [15:0] plane_c;
   logic [15:0] plane_d;
   logic [15:0] focal_len;
   logic [3:0]  batch_index;
   logic [7:0]  cell_row;
   logic [8:0]  cell_col;

   modport source (output valid, plane_a, plane_b, plane_c, plane_d, focal_len,
                   batch_index, cell_row, cell_col, input ready);
   modport sink (input valid, plane_a, plane_b, plane_c, plane_d, focal_len,
                 batch_index, cell_row, cell_col, output ready);
endinterface

// Depth pixel channel.
interface pdu_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  out_batch;
   logic [10:0] pixel_row;
   logic [11:0] pixel_col;
   logic [23:0] depth_value;
   logic        zero_divisor;
   logic        last;

   modport source (output valid, out_batch, pixel_row, pixel_col, depth_value,
                   zero_divisor, last, input ready);
   modport sink (input valid, out_batch, pixel_row, pixel_col, depth_value,
                 zero_divisor, last, output ready);
endinterface

// ----- hw/rtl/planar_depth_upsampler.sv -----
`timescale 1ns / 1ps

// Planar depth upsampler. Each in-range cell item expands into an upratio by
// upratio patch of depth pixels in raster order, last set on the final one;
// cells out of range are dropped. Pixels leave at one per cycle while the
// result is taken, and the next cell is taken in the cycle its predecessor's
// last pixel is launched. The ratio resets to MAX_UPRATIO. The datapath has
// a 31-stage square root and a 25-stage restoring divider. The whole pipeline
// holds when the result is not taken. The ratio written through csr_wdata
// applies from the next cell taken; writes of 0, of odd values above 1 or
// above MAX_UPRATIO are ignored.
module planar_depth_upsampler #(
   parameter int MAX_UPRATIO   = 8,
   parameter int MAX_CELL_ROWS = 256,
   parameter int MAX_CELL_COLS = 512,
   parameter int MAX_BATCH     = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [3:0] csr_wdata,
   pdu_req_if.sink    req_chan,
   pdu_rsp_if.source  rsp_chan
);
   import pdu_pkg::*;

   logic          adv;
   logic          pix_valid;
   pdu_pix_type   pix;
   logic          out_valid;
   pdu_side_type  out_side;
   logic [DEPTH_W-1:0] out_depth;
   logic          out_zero;

   // The pipeline moves whenever its output register is free or being taken.
   assign adv = !out_valid || rsp_chan.ready;

   pdu_cell_seq #(
      .MAX_UPRATIO  (MAX_UPRATIO),
      .MAX_CELL_ROWS(MAX_CELL_ROWS),
      .MAX_CELL_COLS(MAX_CELL_COLS),
      .MAX_BATCH    (MAX_BATCH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req      (req_chan),
      .adv      (adv),
      .pix_valid(pix_valid),
      .pix      (pix)
   );

   pdu_depth_pipe u_pipe (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .pix_valid(pix_valid),
      .pix      (pix),
      .out_valid(out_valid),
      .out_side (out_side),
      .out_depth(out_depth),
      .out_zero (out_zero)
   );

   // Result channel.
   assign rsp_chan.valid        = out_valid;
   assign rsp_chan.out_batch    = out_side.batch;
   assign rsp_chan.pixel_row    = out_side.row;
   assign rsp_chan.pixel_col    = out_side.col;
   assign rsp_chan.depth_value  = out_depth;
   assign rsp_chan.zero_divisor = out_zero;
   assign rsp_chan.last         = out_side.last;

endmodule

// ----- hw/rtl/pdu_cell_seq.sv -----
`timescale 1ns / 1ps

module pdu_cell_seq #(
   parameter int MAX_UPRATIO   = 8,
   parameter int MAX_CELL_ROWS = 256,
   parameter int MAX_CELL_COLS = 512,
   parameter int MAX_BATCH     = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [pdu_pkg::UP_W-1:0] csr_wdata,
   pdu_req_if.sink                 req,
   input  logic                    adv,
   output logic                    pix_valid,
   output pdu_pkg::pdu_pix_type    pix
);
   import pdu_pkg::*;

   localparam int SUB_W = (MAX_UPRATIO > 1) ? $clog2(MAX_UPRATIO) : 1;

   logic [UP_W-1:0]   upratio_ff;
   logic [UP_W-1:0]   up_ff;
   logic              busy_ff;
   logic [SUB_W-1:0]  sr_ff;
   logic [SUB_W-1:0]  sc_ff;
   logic signed [COEF_W-1:0] a_ff, b_ff, c_ff, d_ff;
   logic [COEF_W-1:0] f_ff;
   logic [BATCH_W-1:0] batch_ff;
   logic [CROW_W-1:0] crow_ff;
   logic [CCOL_W-1:0] ccol_ff;
   logic              pix_valid_ff;
   pdu_pix_type       pix_ff;
   pdu_pix_type       pix_in;

   logic              wr_legal;
   logic              in_range;
   logic              accept;
   logic              emit;
   logic              last_pix;
   logic [UP_W-1:0]   up_m1;
   logic [UP_W-1:0]   sr4, sc4;
   logic [CROW_W+UP_W-1:0] row_full;
   logic [CCOL_W+UP_W-1:0] col_full;
   logic [6:0]        tu_full, tv_full;

   // A write is legal for 1 and for even values up to the maximum.
   always_comb begin
      wr_legal = (csr_wdata != '0) && (32'(csr_wdata) <= MAX_UPRATIO) &&
                 ((csr_wdata == UP_W'(1)) || !csr_wdata[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upratio_ff <= UP_W'(MAX_UPRATIO);
      end else if (csr_we && wr_legal) begin
         upratio_ff <= csr_wdata;
      end
   end

   // Handshake: a new cell is taken when idle or when the current patch ends this cycle.
   always_comb begin
      sr4      = UP_W'(sr_ff);
      sc4      = UP_W'(sc_ff);
      up_m1    = up_ff - UP_W'(1);
      last_pix = (sr4 == up_m1) && (sc4 == up_m1);
      emit     = busy_ff && adv;
      req.ready = !busy_ff || (emit && last_pix);
      accept   = req.valid && req.ready;
      in_range = (32'(req.batch_index) < MAX_BATCH) &&
                 (32'(req.cell_row) < MAX_CELL_ROWS) &&
                 (32'(req.cell_col) < MAX_CELL_COLS);
   end

   // Sub-pixel offsets and image coordinates for the current position.
   always_comb begin
      tu_full  = {2'b00, sc4, 1'b0} - {3'b000, up_m1};
      tv_full  = {2'b00, sr4, 1'b0} - {3'b000, up_m1};
      row_full = crow_ff * up_ff + (CROW_W+UP_W)'(sr_ff);
      col_full = ccol_ff * up_ff + (CCOL_W+UP_W)'(sc_ff);
      pix_in.a  = a_ff;
      pix_in.b  = b_ff;
      pix_in.c  = c_ff;
      pix_in.d  = d_ff;
      pix_in.f  = f_ff;
      pix_in.tu = tu_full[TOFS_W-1:0];
      pix_in.tv = tv_full[TOFS_W-1:0];
      pix_in.side.batch = batch_ff;
      pix_in.side.row   = row_full[PROW_W-1:0];
      pix_in.side.col   = col_full[PCOL_W-1:0];
      pix_in.side.last  = last_pix;
   end

   // Cell holding register and patch counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         sr_ff   <= '0;
         sc_ff   <= '0;
      end else if (accept) begin
         busy_ff <= in_range;
         sr_ff   <= '0;
         sc_ff   <= '0;
      end else if (emit) begin
         if (last_pix) begin
            busy_ff <= 1'b0;
         end else if (sc4 == up_m1) begin
            sc_ff <= '0;
            sr_ff <= sr_ff + SUB_W'(1);
         end else begin
            sc_ff <= sc_ff + SUB_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff     <= req.plane_a;
         b_ff     <= req.plane_b;
         c_ff     <= req.plane_c;
         d_ff     <= req.plane_d;
         f_ff     <= req.focal_len;
         batch_ff <= req.batch_index;
         crow_ff  <= req.cell_row;
         ccol_ff  <= req.cell_col;
         up_ff    <= upratio_ff;
      end
   end

   // Launch register into the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
      end else if (adv) begin
         pix_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pix_ff <= pix_in;
      end
   end

   assign pix_valid = pix_valid_ff;
   assign pix       = pix_ff;

endmodule

// ----- hw/rtl/pdu_depth_pipe.sv -----
`timescale 1ns / 1ps

module pdu_depth_pipe (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 pix_valid,
   input  pdu_pkg::pdu_pix_type pix,
   output logic                 out_valid,
   output pdu_pkg::pdu_side_type out_side,
   output logic [pdu_pkg::DEPTH_W-1:0] out_depth,
   output logic                 out_zero
);
   import pdu_pkg::*;

   // Products stage.
   logic                     p1_v_ff;
   logic signed [20:0]       p1_pa_ff, p1_pb_ff;
   logic signed [32:0]       p1_pc_ff;
   logic [7:0]               p1_sq_ff;
   logic [31:0]              p1_ff_ff;
   logic signed [COEF_W-1:0] p1_d_ff;
   logic                     p1_fz_ff;
   pdu_side_type             p1_side_ff;

   // Sum stage.
   logic                     p2_v_ff;
   logic signed [DEN_W-1:0]  p2_den_ff;
   logic [33:0]              p2_q_ff;
   logic signed [COEF_W-1:0] p2_d_ff;
   logic                     p2_fz_ff;
   pdu_side_type             p2_side_ff;

   // Square root stages, index 0 is the setup register.
   logic                     sq_v_ff   [0:SQ_STAGES];
   logic [SQX_W-1:0]         sq_x_ff   [0:SQ_STAGES];
   logic [SQX_W-1:0]         sq_r_ff   [0:SQ_STAGES];
   logic [DMAG_W-1:0]        sq_dmag_ff[0:SQ_STAGES];
   logic [COEF_W:0]          sq_dabs_ff[0:SQ_STAGES];
   pdu_carry_type            sq_cy_ff  [0:SQ_STAGES];

   // Numerator product stage.
   logic                     m_v_ff;
   logic [NMAG_W-1:0]        m_nmag_ff;
   logic [DMAG_W-1:0]        m_dmag_ff;
   pdu_carry_type            m_cy_ff;

   // Divider stages, index 0 is the setup register.
   logic                     dv_v_ff   [0:DIV_STAGES];
   logic [NUM_W-1:0]         dv_rem_ff [0:DIV_STAGES];
   logic [QUO_W-1:0]         dv_q_ff   [0:DIV_STAGES];
   logic [DIV_W-1:0]         dv_div_ff [0:DIV_STAGES];
   logic                     dv_ovf_ff [0:DIV_STAGES];
   pdu_carry_type            dv_cy_ff  [0:DIV_STAGES];

   // Output stage.
   logic                     o_v_ff;
   logic [DEPTH_W-1:0]       o_depth_ff;
   logic                     o_zero_ff;
   pdu_side_type             o_side_ff;

   logic signed [DEN_W-1:0]  den_in;
   logic [33:0]              q_in;
   logic [DMAG_W-1:0]        dmag_in;
   logic [COEF_W:0]          dabs_in;
   logic [NUM_W-1:0]         num_in;
   logic [DIV_W-1:0]         div_in;
   logic                     ovf_in;
   logic [QUO_W-1:0]         mag_in;
   logic [DEPTH_W-1:0]       depth_in;
   logic [QUO_W-1:0]         neg_full;

   // Valid bits of every stage advance together.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         m_v_ff  <= 1'b0;
         o_v_ff  <= 1'b0;
         sq_v_ff[0] <= 1'b0;
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         p1_v_ff <= pix_valid;
         p2_v_ff <= p1_v_ff;
         sq_v_ff[0] <= p2_v_ff;
         m_v_ff  <= sq_v_ff[SQ_STAGES];
         dv_v_ff[0] <= m_v_ff;
         o_v_ff  <= dv_v_ff[DIV_STAGES];
      end
   end

   // Products of the plane terms and the squares.
   always_ff @(posedge clock) begin
      if (adv) begin
         p1_pa_ff   <= 21'(pix.a * pix.tu);
         p1_pb_ff   <= 21'(pix.b * pix.tv);
         p1_pc_ff   <= 33'(pix.c * $signed({1'b0, pix.f}));
         p1_sq_ff   <= 8'(pix.tu * pix.tu + pix.tv * pix.tv);
         p1_ff_ff   <= pix.f * pix.f;
         p1_d_ff    <= pix.d;
         p1_fz_ff   <= (pix.f == '0);
         p1_side_ff <= pix.side;
      end
   end

   // Denominator and radicand sums.
   always_comb begin
      den_in = (DEN_W'(p1_pa_ff) <<< 3) + (DEN_W'(p1_pb_ff) <<< 3) + DEN_W'(p1_pc_ff);
      q_in   = {20'b0, p1_sq_ff, 6'b0} + {2'b0, p1_ff_ff};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_den_ff  <= den_in;
         p2_q_ff    <= q_in;
         p2_d_ff    <= p1_d_ff;
         p2_fz_ff   <= p1_fz_ff;
         p2_side_ff <= p1_side_ff;
      end
   end

   // Setup for the root: magnitudes, sign and the zero-divisor flag.
   always_comb begin
      dmag_in = p2_den_ff[DEN_W-1] ? DMAG_W'(-p2_den_ff) : DMAG_W'(p2_den_ff);
      dabs_in = p2_d_ff[COEF_W-1] ? -{p2_d_ff[COEF_W-1], p2_d_ff}
                                  : {1'b0, p2_d_ff};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_x_ff[0]    <= {p2_q_ff, 28'b0};
         sq_r_ff[0]    <= '0;
         sq_dmag_ff[0] <= dmag_in;
         sq_dabs_ff[0] <= dabs_in;
         sq_cy_ff[0].side <= p2_side_ff;
         sq_cy_ff[0].zero <= p2_fz_ff || (p2_den_ff == '0);
         sq_cy_ff[0].neg  <= p2_d_ff[COEF_W-1] ^ p2_den_ff[DEN_W-1];
      end
   end

   // Square root, one result bit per stage.
   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
      localparam logic [SQX_W-1:0] SQ_BIT = SQX_W'(1) << (2 * (SQ_STAGES - 1 - k));
      logic [SQX_W-1:0] trial;
      logic             take;

      always_comb begin
         trial = sq_r_ff[k] + SQ_BIT;
         take  = sq_x_ff[k] >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_x_ff[k+1]    <= take ? sq_x_ff[k] - trial : sq_x_ff[k];
            sq_r_ff[k+1]    <= take ? (sq_r_ff[k] >> 1) + SQ_BIT : sq_r_ff[k] >> 1;
            sq_dmag_ff[k+1] <= sq_dmag_ff[k];
            sq_dabs_ff[k+1] <= sq_dabs_ff[k];
            sq_cy_ff[k+1]   <= sq_cy_ff[k];
         end
      end
   end

   // Numerator magnitude |d| * root.
   always_ff @(posedge clock) begin
      if (adv) begin
         m_nmag_ff <= NMAG_W'(sq_dabs_ff[SQ_STAGES] * sq_r_ff[SQ_STAGES][ROOT_W-1:0]);
         m_dmag_ff <= sq_dmag_ff[SQ_STAGES];
         m_cy_ff   <= sq_cy_ff[SQ_STAGES];
      end
   end

   // Rounded dividend, doubled divisor and the quotient overflow check.
   always_comb begin
      num_in = {m_nmag_ff, 1'b0} + NUM_W'(m_dmag_ff);
      div_in = {m_dmag_ff, 1'b0};
      ovf_in = CMP_W'(num_in) >= {div_in, QUO_W'(0)};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff[0] <= num_in;
         dv_q_ff[0]   <= '0;
         dv_div_ff[0] <= div_in;
         dv_ovf_ff[0] <= ovf_in;
         dv_cy_ff[0]  <= m_cy_ff;
      end
   end

   // Restoring divider, one quotient bit per stage, most significant first.
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      localparam int SH = DIV_STAGES - 1 - i;
      logic [CMP_W-1:0] trial;
      logic [CMP_W-1:0] rem_ext;
      logic             take;
      logic [CMP_W-1:0] diff;

      always_comb begin
         trial   = CMP_W'(dv_div_ff[i]) << SH;
         rem_ext = CMP_W'(dv_rem_ff[i]);
         take    = rem_ext >= trial;
         diff    = rem_ext - trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[i+1] <= dv_v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[i+1] <= take ? diff[NUM_W-1:0] : dv_rem_ff[i];
            dv_q_ff[i+1]   <= dv_q_ff[i] | (take ? (QUO_W'(1) << SH) : '0);
            dv_div_ff[i+1] <= dv_div_ff[i];
            dv_ovf_ff[i+1] <= dv_ovf_ff[i];
            dv_cy_ff[i+1]  <= dv_cy_ff[i];
         end
      end
   end

   // Sign, saturation and the zero-divisor override.
   always_comb begin
      if (dv_cy_ff[DIV_STAGES].neg) begin
         mag_in = (dv_ovf_ff[DIV_STAGES] || dv_q_ff[DIV_STAGES] > DEPTH_NEG_MAG)
                  ? DEPTH_NEG_MAG : dv_q_ff[DIV_STAGES];
      end else begin
         mag_in = (dv_ovf_ff[DIV_STAGES] || dv_q_ff[DIV_STAGES] > DEPTH_POS_MAG)
                  ? DEPTH_POS_MAG : dv_q_ff[DIV_STAGES];
      end
      neg_full = -mag_in;
      if (dv_cy_ff[DIV_STAGES].zero) begin
         depth_in = '0;
      end else if (dv_cy_ff[DIV_STAGES].neg) begin
         depth_in = neg_full[DEPTH_W-1:0];
      end else begin
         depth_in = mag_in[DEPTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_depth_ff <= depth_in;
         o_zero_ff  <= dv_cy_ff[DIV_STAGES].zero;
         o_side_ff  <= dv_cy_ff[DIV_STAGES].side;
      end
   end

   assign out_valid = o_v_ff;
   assign out_side  = o_side_ff;
   assign out_depth = o_depth_ff;
   assign out_zero  = o_zero_ff;

endmodule

// ----- hw/rtl/pdu_checker.sv -----
`timescale 1ns / 1ps

module pdu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_depth,
   input logic        rsp_zero
);

   // A pixel on hold stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("pixel dropped while stalled");

   // A pixel on hold keeps its depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_depth))
      else $error("depth changed while stalled");

   // A zero divisor always yields a zero depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero |-> rsp_depth == 24'd0)
      else $error("zero divisor with nonzero depth");

   // Nothing is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel offered after reset");

endmodule

bind planar_depth_upsampler pdu_checker u_pdu_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_depth(rsp_chan.depth_value),
   .rsp_zero (rsp_chan.zero_divisor)
);
